// File: rtl/text_console_writer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the text console writer checker.
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Generic property check.
`define TCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("text console writer assertion failed");

// A word that is offered and not taken stays offered and unchanged.
`define TCW_ASSERT_HOLD(lbl, vld, rdy, dat) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(dat))) \
    else $error("text console writer word dropped or changed while stalled");

`endif

// File: rtl/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// Types and fixed constants shared by the text console writer modules.
// ---------------------------------------------------------------------------
package tcw_pkg;

  // Field widths fixed by the request and result formats.
  localparam int unsigned ReqW   = 2;
  localparam int unsigned CharW  = 8;
  localparam int unsigned IdxW   = 11;
  localparam int unsigned ColW   = 7;
  localparam int unsigned RowW   = 5;
  localparam int unsigned LocW   = 11;
  localparam int unsigned ColorW = 4;
  localparam int unsigned AttrW  = 8;
  localparam int unsigned CellW  = 16;

  // Depth of the command queue between front and back.
  localparam int unsigned QDepth = 2;

  // Request type codes.
  localparam logic [ReqW-1:0] REQ_PUT   = 2'd0;
  localparam logic [ReqW-1:0] REQ_CLEAR = 2'd1;
  localparam logic [ReqW-1:0] REQ_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_FORE = 1'b0;
  localparam logic CFG_BACK = 1'b1;

  // Special characters.
  localparam logic [CharW-1:0] CHAR_LF    = 8'd10;
  localparam logic [CharW-1:0] CHAR_CR    = 8'd13;
  localparam logic [CharW-1:0] CHAR_SPACE = 8'd32;

  // Reset and reset colors.
  localparam logic [ColorW-1:0] FORE_RESET = 4'hF;
  localparam logic [ColorW-1:0] BACK_RESET = 4'h0;

  // A blank cell: space with attribute zero (attribute in the high byte).
  localparam logic [CellW-1:0] BLANK_CELL = {8'h00, CHAR_SPACE};

  // Classified operations handed from front to back.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_LF,
    OP_CR,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [CharW-1:0] char_code;
    logic [IdxW-1:0]  cell_index;
  } req_t;

  typedef struct packed {
    logic [CharW-1:0] read_char;
    logic [AttrW-1:0] read_attr;
    logic [ColW-1:0]  cursor_col;
    logic [RowW-1:0]  cursor_row;
    logic [LocW-1:0]  cursor_location;
    logic             scrolled;
  } rsp_t;

  typedef struct packed {
    op_e              op;
    logic [CharW-1:0] char_code;
    logic [IdxW-1:0]  cell_index;
    logic [AttrW-1:0] attr;
  } cmd_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

// File: rtl/tcw_stream_if.sv
// ---------------------------------------------------------------------------
// tcw_stream_if
// Valid/ready channel carrying one payload word of type T.
// ---------------------------------------------------------------------------
interface tcw_stream_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);

endinterface

// File: rtl/text_console_writer.sv
// ---------------------------------------------------------------------------
// text_console_writer
// Teletype-style text console over a COLS x ROWS grid of character cells.
// ---------------------------------------------------------------------------
//  channel  dir  word    contents
//  req_i    in   req_t   req_type, char_code, cell_index
//  rsp_o    out  rsp_t   read_char, read_attr, cursor, cursor_location, scrolled
//  cfg      in   write   cfg_we_i, cfg_idx_i (0 fore, 1 back), cfg_data_i
//
// A plain put, carriage return, line feed without scroll or out-of-range read
// completes from the idle state, a read waits for the registered memory read,
// and a clear or a scroll sweeps the grid one cell per cycle through the single
// memory write port. After reset a clearing pass blanks the memory; no request
// is taken then, configuration writes are.
// A two-word command queue lets requests enter while the result waits.
// ---------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcw_stream_if.sink        req_i,
  tcw_stream_if.source      rsp_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [ColorW-1:0] cfg_data_i
);

  head_t head;
  logic  pop;
  logic  busy;
  logic  req_ready;
  logic  rsp_valid;
  rsp_t  rsp_data;

  // Front end: classify and queue.
  tcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .req_data_i  (req_i.data),
    .busy_i      (busy),
    .pop_i       (pop),
    .head_o      (head)
  );

  // Back end: memory, cursor and result.
  tcw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .busy_o      (busy),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_data_o  (rsp_data)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;
  assign rsp_o.data  = rsp_data;

endmodule

// File: rtl/tcw_ram.sv
// ---------------------------------------------------------------------------
// tcw_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tcw_front.sv
// ---------------------------------------------------------------------------
// tcw_front
// Accepts requests, classifies them and queues them for the back end.
// Also holds the color registers and stamps each put with its attribute.
// ---------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [ColorW-1:0] cfg_data_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  req_t              req_data_i,
  input  logic              busy_i,
  input  logic              pop_i,
  output head_t             head_o
);

  localparam int unsigned Total = COLS * ROWS;
  localparam int unsigned PtrW  = $clog2(QDepth);
  localparam int unsigned CntW  = $clog2(QDepth + 1);

  logic [ColorW-1:0] fore_q, fore_d;
  logic [ColorW-1:0] back_q, back_d;
  cmd_t              slot_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  cmd_t              cmd;
  logic              push;

  // Color registers.
  always_comb begin
    fore_d = fore_q;
    back_d = back_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FORE: fore_d = cfg_data_i;
        CFG_BACK: back_d = cfg_data_i;
        default: begin
          fore_d = fore_q;
        end
      endcase
    end
  end

  // Classify the incoming word into a back end operation.
  always_comb begin
    cmd.char_code  = req_data_i.char_code;
    cmd.cell_index = req_data_i.cell_index;
    cmd.attr       = {back_q, fore_q};
    case (req_data_i.req_type)
      REQ_PUT: begin
        if (req_data_i.char_code == CHAR_LF) begin
          cmd.op = OP_LF;
        end else if (req_data_i.char_code == CHAR_CR) begin
          cmd.op = OP_CR;
        end else begin
          cmd.op = OP_PUT;
        end
      end
      REQ_CLEAR: cmd.op = OP_CLEAR;
      REQ_READ: begin
        // A read beyond the screen only reports the cursor.
        if (32'(req_data_i.cell_index) < Total) begin
          cmd.op = OP_READ;
        end else begin
          cmd.op = OP_NOP;
        end
      end
      default: cmd.op = OP_NOP;
    endcase
  end

  // Queue control.
  assign req_ready_o = (cnt_q != CntW'(QDepth)) && !busy_i;
  assign push        = req_valid_i && req_ready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_q   <= FORE_RESET;
      back_q   <= BACK_RESET;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      fore_q   <= fore_d;
      back_q   <= back_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

// File: rtl/tcw_back.sv
// ---------------------------------------------------------------------------
// tcw_back
// Executes queued operations on the cell memory, tracks the cursor and
// holds the result register. Scroll and clear run as cell sweeps.
// ---------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  head_t head_i,
  output logic  pop_o,
  output logic  busy_o,
  output logic  rsp_valid_o,
  input  logic  rsp_ready_i,
  output rsp_t  rsp_data_o
);

  localparam int unsigned Total   = COLS * ROWS;
  localparam int unsigned AW      = $clog2(Total);
  localparam int unsigned CopyEnd = (ROWS - 1) * COLS;
  localparam int unsigned ExtW    = (AW > LocW) ? AW : LocW;

  localparam logic [AW-1:0]   LAST_ROW_LOC = AW'(CopyEnd);
  localparam logic [AW-1:0]   LAST_CELL    = AW'(Total - 1);
  localparam logic [ColW-1:0] LAST_COL     = ColW'(COLS - 1);
  localparam logic [RowW-1:0] LAST_ROW     = RowW'(ROWS - 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [AW-1:0]   loc_q, loc_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic            copy_q, copy_d;
  logic            init_q, init_d;
  logic            scr_q, scr_d;
  logic            pend_q, pend_d;
  logic            pend_blank_q, pend_blank_d;
  logic [AW-1:0]   pend_addr_q, pend_addr_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;

  logic             out_free;
  logic             out_load;
  logic [CharW-1:0] res_char;
  logic [AttrW-1:0] res_attr;
  logic             res_scr;
  logic [ExtW-1:0]  loc_ext;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [CellW-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [CellW-1:0] ram_rdata;

  assign out_free = !out_valid_q || rsp_ready_i;

  // Operation sequencer.
  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    loc_d        = loc_q;
    ptr_d        = ptr_q;
    copy_d       = copy_q;
    init_d       = init_q;
    scr_d        = scr_q;
    pend_d       = 1'b0;
    pend_blank_d = pend_blank_q;
    pend_addr_d  = pend_addr_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    pop_o        = 1'b0;
    out_load     = 1'b0;
    res_char     = '0;
    res_attr     = '0;
    res_scr      = 1'b0;

    // A sweep write lands in the cycle after its read was issued.
    if (pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = pend_blank_q ? BLANK_CELL : ram_rdata;
    end

    case (state_q)
      ST_IDLE: begin
        if (head_i.valid && out_free) begin
          pop_o = 1'b1;
          case (head_i.cmd.op)
            OP_PUT: begin
              ram_we    = 1'b1;
              ram_waddr = loc_q;
              ram_wdata = {head_i.cmd.attr, head_i.cmd.char_code};
              if (col_q == LAST_COL) begin
                col_d = '0;
                if (row_q == LAST_ROW) begin
                  loc_d   = LAST_ROW_LOC;
                  state_d = ST_SWEEP;
                  ptr_d   = '0;
                  copy_d  = 1'b1;
                  scr_d   = 1'b1;
                end else begin
                  row_d    = row_q + 1'b1;
                  loc_d    = loc_q + 1'b1;
                  out_load = 1'b1;
                end
              end else begin
                col_d    = col_q + 1'b1;
                loc_d    = loc_q + 1'b1;
                out_load = 1'b1;
              end
            end
            OP_LF: begin
              col_d = '0;
              if (row_q == LAST_ROW) begin
                loc_d   = LAST_ROW_LOC;
                state_d = ST_SWEEP;
                ptr_d   = '0;
                copy_d  = 1'b1;
                scr_d   = 1'b1;
              end else begin
                row_d    = row_q + 1'b1;
                loc_d    = loc_q - AW'(col_q) + AW'(COLS);
                out_load = 1'b1;
              end
            end
            OP_CR: begin
              col_d    = '0;
              loc_d    = loc_q - AW'(col_q);
              out_load = 1'b1;
            end
            OP_CLEAR: begin
              state_d = ST_SWEEP;
              ptr_d   = '0;
              copy_d  = 1'b0;
              scr_d   = 1'b0;
            end
            OP_READ: begin
              ram_re    = 1'b1;
              ram_raddr = AW'(head_i.cmd.cell_index);
              state_d   = ST_READ;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        // Copy one cell up a row, or blank it below the copied region.
        pend_d      = 1'b1;
        pend_addr_d = ptr_q;
        if (copy_q && (32'(ptr_q) < CopyEnd)) begin
          ram_re       = 1'b1;
          ram_raddr    = AW'(32'(ptr_q) + COLS);
          pend_blank_d = 1'b0;
        end else begin
          pend_blank_d = 1'b1;
        end
        if (ptr_q == LAST_CELL) begin
          state_d = ST_DRAIN;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // The last sweep write retires here; the reset pass gives no result.
        if (init_q) begin
          init_d  = 1'b0;
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          res_scr  = scr_q;
          state_d  = ST_IDLE;
        end
      end
      ST_READ: begin
        out_load = 1'b1;
        res_char = ram_rdata[CharW-1:0];
        res_attr = ram_rdata[CellW-1:CharW];
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register.
  assign loc_ext = ExtW'(loc_d);

  always_comb begin
    out_d = out_q;
    if (out_load) begin
      out_d.read_char       = res_char;
      out_d.read_attr       = res_attr;
      out_d.cursor_col      = col_d;
      out_d.cursor_row      = row_d;
      out_d.cursor_location = loc_ext[LocW-1:0];
      out_d.scrolled        = res_scr;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      col_q        <= '0;
      row_q        <= '0;
      loc_q        <= '0;
      ptr_q        <= '0;
      copy_q       <= 1'b0;
      init_q       <= 1'b1;
      scr_q        <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      row_q        <= row_d;
      loc_q        <= loc_d;
      ptr_q        <= ptr_d;
      copy_q       <= copy_d;
      init_q       <= init_d;
      scr_q        <= scr_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_blank_q <= pend_blank_d;
    pend_addr_q  <= pend_addr_d;
    out_q        <= out_d;
  end

  // Cell memory: character in the low byte, attribute in the high byte.
  tcw_ram #(
    .Width (CellW),
    .Depth (Total)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy_o      = init_q;
  assign rsp_valid_o = out_valid_q;
  assign rsp_data_o  = out_q;

endmodule

// File: rtl/tcw_checker.sv
// ---------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the console results, bound to the top level.
// ---------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_checker import tcw_pkg::*; #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input logic clk_i,
  input logic rst_ni,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_data_i
);

  logic [LocW-1:0] exp_loc;
  logic            in_grid;
  logic            scroll_ok;

  // Linear location implied by the reported row and column.
  assign exp_loc = LocW'(32'(rsp_data_i.cursor_row) * COLS + 32'(rsp_data_i.cursor_col));

  // The reported cursor lies inside the grid.
  assign in_grid = (32'(rsp_data_i.cursor_col) < COLS) &&
                   (32'(rsp_data_i.cursor_row) < ROWS);

  // A scroll leaves the cursor on the last row and reads nothing.
  assign scroll_ok = (32'(rsp_data_i.cursor_row) == ROWS - 1) &&
                     (rsp_data_i.read_char == '0) && (rsp_data_i.read_attr == '0);

  `TCW_ASSERT_HOLD(a_rsp_hold, rsp_valid_i, rsp_ready_i, rsp_data_i)

  `TCW_ASSERT(a_cursor_in_grid, rsp_valid_i |-> in_grid)

  `TCW_ASSERT(a_location_match, rsp_valid_i |-> (rsp_data_i.cursor_location == exp_loc))

  `TCW_ASSERT(a_scroll_last_row, (rsp_valid_i && rsp_data_i.scrolled) |-> scroll_ok)

endmodule

bind text_console_writer tcw_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

// File: sim/text_console_writer_checker.sv
// ---------------------------------------------------------------------------
// text_console_writer_checker
// Watches the request, result and color-write ports of the text console
// writer. It keeps its own screen, cursor and colors, works out the report
// each accepted request word should produce, and compares the result words
// field by field, in order, against those reports.
// ---------------------------------------------------------------------------
module text_console_writer_checker import tcw_pkg::*; #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcw_stream_if.mon         req_i,
  tcw_stream_if.mon         rsp_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [ColorW-1:0] cfg_data_i,
  output int                fault_count_o,
  output int                reports_waiting_o
);

  localparam int unsigned CellCount = COLS * ROWS;

  logic [CellW-1:0]  screen [CellCount];
  logic [ColW-1:0]   col_q;
  logic [RowW-1:0]   row_q;
  logic [ColorW-1:0] fore_q;
  logic [ColorW-1:0] back_q;
  rsp_t              console_reports [$];
  rsp_t              got;
  rsp_t              want;

  // Count a fault and print it.
  function automatic void flag(input string what, input longint unsigned want_v,
                               input longint unsigned got_v);
    fault_count_o++;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
  endfunction

  // Step the cursor down one row; at the bottom the screen scrolls up instead.
  function automatic logic advance_row();
    if (row_q == RowW'(ROWS - 1)) begin
      for (int i = 0; i < CellCount - COLS; i++) screen[i] = screen[i + COLS];
      for (int i = CellCount - COLS; i < CellCount; i++) screen[i] = BLANK_CELL;
      return 1'b1;
    end
    row_q = row_q + 1'b1;
    return 1'b0;
  endfunction

  // Apply one request to the screen and cursor and build its report.
  function automatic rsp_t console_report(input req_t r);
    rsp_t        rep;
    int unsigned loc;
    rep = '0;
    case (r.req_type)
      REQ_PUT: begin
        if (r.char_code == CHAR_LF) begin
          col_q = '0;
          rep.scrolled = advance_row();
        end else if (r.char_code == CHAR_CR) begin
          col_q = '0;
        end else begin
          loc = row_q * COLS + col_q;
          screen[loc] = {back_q, fore_q, r.char_code};
          // The cursor wraps as soon as the last column is written.
          if (col_q == ColW'(COLS - 1)) begin
            col_q = '0;
            rep.scrolled = advance_row();
          end else begin
            col_q = col_q + 1'b1;
          end
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < CellCount; i++) screen[i] = BLANK_CELL;
      end
      REQ_READ: begin
        // Reads past the end of the screen return zeros.
        if (r.cell_index < CellCount) {rep.read_attr, rep.read_char} = screen[r.cell_index];
      end
      default: begin
      end
    endcase
    rep.cursor_col      = col_q;
    rep.cursor_row      = row_q;
    rep.cursor_location = LocW'(row_q * COLS + col_q);
    return rep;
  endfunction

  // Compare result words first, then take color writes and new requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CellCount; i++) screen[i] = BLANK_CELL;
      col_q  = '0;
      row_q  = '0;
      fore_q = FORE_RESET;
      back_q = BACK_RESET;
      console_reports.delete();
      fault_count_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got = rsp_i.data;
        if (console_reports.size() == 0) begin
          fault_count_o++;
          $display("%0t: result mismatch: expected no word, got %h", $time, got);
        end else begin
          want = console_reports.pop_front();
          if (got.read_char != want.read_char)
            flag("read_char", want.read_char, got.read_char);
          if (got.read_attr != want.read_attr)
            flag("read_attr", want.read_attr, got.read_attr);
          if (got.cursor_col != want.cursor_col)
            flag("cursor_col", want.cursor_col, got.cursor_col);
          if (got.cursor_row != want.cursor_row)
            flag("cursor_row", want.cursor_row, got.cursor_row);
          if (got.cursor_location != want.cursor_location)
            flag("cursor_location", want.cursor_location, got.cursor_location);
          if (got.scrolled != want.scrolled)
            flag("scrolled", want.scrolled, got.scrolled);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FORE) fore_q = cfg_data_i;
        else back_q = cfg_data_i;
      end
      if (req_i.valid && req_i.ready) console_reports.push_back(console_report(req_i.data));
    end
    reports_waiting_o = console_reports.size();
  end

endmodule

// File: sim/text_console_writer_tb.sv
// ---------------------------------------------------------------------------
// text_console_writer_tb
// Drives the text console writer with a short directed sequence and then
// random puts, line feeds, carriage returns, reads and clears under three
// idling patterns and a long result hold-off. Colors are rewritten between
// phases. The checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int unsigned COLS         = 80;
  localparam int unsigned ROWS         = 25;
  localparam int unsigned CellCount    = COLS * ROWS;
  localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned StallLimit   = 20000;
  localparam int unsigned SettleCycles = CellCount + 10;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned PhaseItems   = 450;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              cfg_we_i   = 1'b0;
  logic              cfg_idx_i  = CFG_FORE;
  logic [ColorW-1:0] cfg_data_i = '0;
  int                fault_count;
  int                reports_waiting;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_requests = 0;
  int                holds_served  = 0;
  int                hold_left     = 0;
  int                quiet_cycles  = 0;

  tcw_stream_if #(.T(req_t)) req_if ();
  tcw_stream_if #(.T(rsp_t)) rsp_if ();

  text_console_writer #(.COLS(COLS), .ROWS(ROWS)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  text_console_writer_checker #(.COLS(COLS), .ROWS(ROWS)) console_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_i             (req_if),
    .rsp_i             (rsp_if),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .fault_count_o     (fault_count),
    .reports_waiting_o (reports_waiting)
  );

  always #2 clk_i = ~clk_i;

  // Result side: random stalls, or a long counted hold-off when one is asked for.
  always @(posedge clk_i) begin
    if (hold_requests != holds_served) begin
      holds_served  <= hold_requests;
      hold_left     <= LongHold;
      rsp_if.ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // End the run when no word moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request word, after a random gap, and hold it until taken.
  task automatic offer_request(input logic [ReqW-1:0] kind, input logic [CharW-1:0] ch,
                               input logic [IdxW-1:0] idx);
    req_t w;
    w.req_type   = kind;
    w.char_code  = ch;
    w.cell_index = idx;
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Mostly text and line control, with reads, a few clears and unused codes.
  task automatic offer_random_request();
    int unsigned      pick;
    logic [ReqW-1:0]  kind;
    logic [CharW-1:0] ch;
    logic [IdxW-1:0]  idx;
    pick = $urandom_range(99);
    ch   = CharW'($urandom_range(255));
    idx  = IdxW'($urandom_range(2047));
    kind = REQ_PUT;
    if (pick < 60) begin
      kind = REQ_PUT;
    end else if (pick < 68) begin
      ch = CHAR_LF;
    end else if (pick < 72) begin
      ch = CHAR_CR;
    end else if (pick < 96) begin
      kind = REQ_READ;
      // Favor the bottom rows, where the cursor lives once the screen scrolls.
      if (pick < 84) idx = IdxW'($urandom_range(CellCount - 1, CellCount - 5 * COLS));
      else if (pick < 93) idx = IdxW'($urandom_range(CellCount - 1));
    end else if (pick < 97) begin
      kind = REQ_CLEAR;
    end else begin
      kind = REQ_UNUSED;
    end
    offer_request(kind, ch, idx);
  endtask

  // Drop valid after the last word and wait until every result is back.
  task automatic finish_phase();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (reports_waiting != 0);
  endtask

  // Colors change only while the console is idle.
  task automatic write_colors(input logic [ColorW-1:0] fore, input logic [ColorW-1:0] back);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FORE;
    cfg_data_i <= fore;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BACK;
    cfg_data_i <= back;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct,
                                  input bit with_hold);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    for (int n = 0; n < PhaseItems; n++) begin
      if (with_hold && n == PhaseItems / 2) hold_requests <= hold_requests + 1;
      offer_random_request();
    end
    finish_phase();
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset colors, byte extremes, line control, read edges, clear.
    offer_request(REQ_PUT, 8'h41, '0);
    offer_request(REQ_PUT, 8'h00, '0);
    offer_request(REQ_PUT, 8'hFF, 11'h7FF);
    offer_request(REQ_PUT, CHAR_CR, '0);
    offer_request(REQ_PUT, 8'h42, '0);
    offer_request(REQ_PUT, CHAR_LF, '0);
    offer_request(REQ_READ, 8'hFF, 11'd0);
    offer_request(REQ_READ, 8'h00, 11'd1);
    offer_request(REQ_READ, 8'h00, 11'd2);
    offer_request(REQ_READ, 8'h00, 11'd80);
    offer_request(REQ_READ, 8'h00, IdxW'(CellCount - 1));
    offer_request(REQ_READ, 8'h00, IdxW'(CellCount));
    offer_request(REQ_READ, 8'hFF, 11'h7FF);
    offer_request(REQ_UNUSED, 8'hFF, 11'h7FF);
    offer_request(REQ_PUT, 8'h43, '0);
    offer_request(REQ_CLEAR, 8'h00, '0);
    offer_request(REQ_READ, 8'h00, 11'd0);
    offer_request(REQ_READ, 8'h00, 11'd80);
    offer_request(REQ_PUT, 8'h7E, '0);
    offer_request(REQ_READ, 8'h00, 11'd81);
    finish_phase();

    write_colors(4'h0, 4'hF);
    run_random_phase(23, 68, 1'b1);
    write_colors(4'hF, 4'h0);
    run_random_phase(68, 23, 1'b0);
    write_colors(ColorW'($urandom_range(15)), ColorW'($urandom_range(15)));
    run_random_phase(0, 0, 1'b1);

    // Leave room for any stray result word before the verdict.
    repeat (SettleCycles) @(posedge clk_i);
    if (fault_count == 0 && reports_waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_stream_if.sv
rtl/tcw_ram.sv
rtl/tcw_front.sv
rtl/tcw_back.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
sim/text_console_writer_checker.sv
sim/text_console_writer_tb.sv
